// File: hw/rtl/rfr_pkg.sv
// Shared types and constants for the response frame receiver.
// Used by rfr_parser and response_frame_receiver_core; depends on nothing else.
package rfr_pkg;

  // Request command codes carried in the input tuser.
  localparam logic [1:0] CMD_ARM  = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Result kinds carried in the output tuser.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  // Outcome codes of a finished wait.
  localparam logic [1:0] OUTC_OK      = 2'd0;
  localparam logic [1:0] OUTC_BAD_SUM = 2'd1;
  localparam logic [1:0] OUTC_TIMEOUT = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_HEADER_WORD   = 3'd0;
  localparam logic [2:0] REG_ACK_TYPE      = 3'd1;
  localparam logic [2:0] REG_DATA_TYPE     = 3'd2;
  localparam logic [2:0] REG_LAST_TYPE     = 3'd3;
  localparam logic [2:0] REG_MAX_PAYLOAD   = 3'd4;

  // Configuration reset values.
  localparam logic [15:0] RST_HEADER_WORD = 16'hEF01;
  localparam logic [7:0]  RST_ACK_TYPE    = 8'd7;
  localparam logic [7:0]  RST_DATA_TYPE   = 8'd2;
  localparam logic [7:0]  RST_LAST_TYPE   = 8'd8;
  localparam logic [15:0] RST_MAX_PAYLOAD = 16'd256;

  // Header parser positions while seeking a frame.
  localparam logic [3:0] HC_FIRST   = 4'd0;
  localparam logic [3:0] HC_SECOND  = 4'd1;
  localparam logic [3:0] HC_ADDR0   = 4'd2;
  localparam logic [3:0] HC_ADDR3   = 4'd5;
  localparam logic [3:0] HC_TYPE    = 4'd6;
  localparam logic [3:0] HC_LEN_HI  = 4'd7;
  localparam logic [3:0] HC_LEN_LO  = 4'd8;
  localparam logic [3:0] HC_CONFIRM = 4'd9;

  // Length bytes that are not payload: type-dependent trailer accounting.
  localparam logic [15:0] OVERHEAD_DATA = 16'd2;
  localparam logic [15:0] OVERHEAD_ACK  = 16'd3;

  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SEEK  = 3'd1,
    PH_BODY  = 3'd2,
    PH_SUMHI = 3'd3,
    PH_SUMLO = 3'd4
  } phase_t;

  typedef struct packed {
    logic [15:0] header_word;
    logic [7:0]  ack_type;
    logic [7:0]  data_type;
    logic [7:0]  last_type;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        wait_data;
    logic [15:0] timeout_ticks;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] byte_index;
    logic [7:0]  payload_byte;
    logic [1:0]  outcome;
    logic [7:0]  confirm_code;
    logic [7:0]  frame_type;
  } result_t;

endpackage

// File: hw/rtl/rfr_parser.sv
// Frame parser state and per-request next-state logic of the response frame receiver.
// Depends on rfr_pkg; the result it computes is registered by the top level.
module rfr_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_i,
  input  rfr_pkg::item_t  item_i,
  input  rfr_pkg::cfg_t   cfg_i,
  output logic            res_valid_o,
  output rfr_pkg::result_t res_o
);
  import rfr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        expect_r, expect_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  first_hdr_r, first_hdr_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  confirm_r, confirm_nxt;
  logic [7:0]  sum_hi_r, sum_hi_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [15:0] limit_r, limit_nxt;

  logic [7:0]  b;
  logic [15:0] len_src;
  logic [15:0] overhead;
  logic [15:0] count_raw;
  logic [15:0] body_count;
  logic [15:0] ticks_inc;
  logic        type_ok;
  logic [15:0] left_dec;

  assign b = item_i.rx_byte;

  // The length is complete either with the low length byte (data) or already stored (ack).
  assign len_src  = (hdr_cnt_r == HC_LEN_LO) ? {length_r[15:8], b} : length_r;
  assign overhead = expect_r ? OVERHEAD_DATA : OVERHEAD_ACK;
  assign count_raw = (len_src >= overhead) ? (len_src - overhead) : 16'd0;
  assign body_count = (expect_r && (count_raw > cfg_i.max_payload)) ? cfg_i.max_payload
                                                                     : count_raw;

  assign ticks_inc = (ticks_r != TICKS_MAX) ? (ticks_r + 16'd1) : ticks_r;
  assign type_ok   = expect_r ? ((b == cfg_i.data_type) || (b == cfg_i.last_type))
                              : (b == cfg_i.ack_type);
  assign left_dec  = left_r - 16'd1;

  always_comb begin
    phase_nxt     = phase_r;
    expect_nxt    = expect_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    first_hdr_nxt = first_hdr_r;
    type_nxt      = type_r;
    length_nxt    = length_r;
    left_nxt      = left_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    confirm_nxt   = confirm_r;
    sum_hi_nxt    = sum_hi_r;
    ticks_nxt     = ticks_r;
    limit_nxt     = limit_r;

    if (step_i) begin
      unique case (item_i.cmd)
        CMD_ARM: begin
          expect_nxt    = item_i.wait_data;
          limit_nxt     = item_i.timeout_ticks;
          ticks_nxt     = '0;
          hdr_cnt_nxt   = HC_FIRST;
          first_hdr_nxt = '0;
          type_nxt      = '0;
          length_nxt    = '0;
          left_nxt      = '0;
          pos_nxt       = '0;
          sum_nxt       = '0;
          confirm_nxt   = '0;
          sum_hi_nxt    = '0;
          phase_nxt     = PH_SEEK;
        end
        CMD_TICK: begin
          // Only the header search is timed.
          if (phase_r == PH_SEEK) begin
            ticks_nxt = ticks_inc;
            if (ticks_inc >= limit_r) begin
              phase_nxt   = PH_IDLE;
              hdr_cnt_nxt = HC_FIRST;
            end
          end
        end
        CMD_BYTE: begin
          unique case (phase_r)
            PH_SEEK: begin
              case (hdr_cnt_r) inside
                HC_FIRST: begin
                  first_hdr_nxt = b;
                  hdr_cnt_nxt   = HC_SECOND;
                end
                HC_SECOND: begin
                  if ((first_hdr_r == cfg_i.header_word[15:8]) &&
                      (b == cfg_i.header_word[7:0])) begin
                    hdr_cnt_nxt = HC_ADDR0;
                  end else begin
                    hdr_cnt_nxt = HC_FIRST;
                  end
                end
                [HC_ADDR0:HC_ADDR3]: begin
                  hdr_cnt_nxt = hdr_cnt_r + 4'd1;
                end
                HC_TYPE: begin
                  if (type_ok) begin
                    type_nxt    = b;
                    hdr_cnt_nxt = HC_LEN_HI;
                  end else begin
                    hdr_cnt_nxt = HC_FIRST;
                  end
                end
                HC_LEN_HI: begin
                  length_nxt  = {b, 8'd0};
                  hdr_cnt_nxt = HC_LEN_LO;
                end
                HC_LEN_LO: begin
                  length_nxt = len_src;
                  sum_nxt    = {8'd0, type_r} + {8'd0, length_r[15:8]} + {8'd0, b};
                  if (expect_r) begin
                    left_nxt    = body_count;
                    pos_nxt     = '0;
                    hdr_cnt_nxt = HC_FIRST;
                    phase_nxt   = (body_count != 16'd0) ? PH_BODY : PH_SUMHI;
                  end else begin
                    hdr_cnt_nxt = HC_CONFIRM;
                  end
                end
                HC_CONFIRM: begin
                  confirm_nxt = b;
                  sum_nxt     = sum_r + {8'd0, b};
                  left_nxt    = body_count;
                  pos_nxt     = '0;
                  hdr_cnt_nxt = HC_FIRST;
                  phase_nxt   = (body_count != 16'd0) ? PH_BODY : PH_SUMHI;
                end
                default: begin
                  hdr_cnt_nxt = HC_FIRST;
                end
              endcase
            end
            PH_BODY: begin
              sum_nxt  = sum_r + {8'd0, b};
              pos_nxt  = pos_r + 16'd1;
              left_nxt = left_dec;
              if (left_dec == 16'd0) begin
                phase_nxt = PH_SUMHI;
              end
            end
            PH_SUMHI: begin
              sum_hi_nxt = b;
              phase_nxt  = PH_SUMLO;
            end
            PH_SUMLO: begin
              phase_nxt = PH_IDLE;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      unique case (item_i.cmd)
        CMD_TICK: begin
          if ((phase_r == PH_SEEK) && (ticks_inc >= limit_r)) begin
            res_valid_o   = 1'b1;
            res_o.kind    = KIND_DONE;
            res_o.outcome = OUTC_TIMEOUT;
          end
        end
        CMD_BYTE: begin
          unique case (phase_r)
            PH_BODY: begin
              res_valid_o        = 1'b1;
              res_o.kind         = KIND_PAYLOAD;
              res_o.byte_index   = pos_r;
              res_o.payload_byte = b;
            end
            PH_SUMLO: begin
              res_valid_o        = 1'b1;
              res_o.kind         = KIND_DONE;
              res_o.outcome      = ({sum_hi_r, b} == sum_r) ? OUTC_OK : OUTC_BAD_SUM;
              res_o.confirm_code = expect_r ? 8'd0 : confirm_r;
              res_o.frame_type   = type_r;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      expect_r    <= 1'b0;
      hdr_cnt_r   <= HC_FIRST;
      first_hdr_r <= '0;
      type_r      <= '0;
      length_r    <= '0;
      left_r      <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      confirm_r   <= '0;
      sum_hi_r    <= '0;
      ticks_r     <= '0;
      limit_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      expect_r    <= expect_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      first_hdr_r <= first_hdr_nxt;
      type_r      <= type_nxt;
      length_r    <= length_nxt;
      left_r      <= left_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      confirm_r   <= confirm_nxt;
      sum_hi_r    <= sum_hi_nxt;
      ticks_r     <= ticks_nxt;
      limit_r     <= limit_nxt;
    end
  end

endmodule

// File: hw/rtl/response_frame_receiver_core.sv
// Top level of the response frame receiver: stream ports, input and result registers,
// configuration registers. Depends on rfr_pkg and rfr_parser.
//
// Usage: each input request carries a command in in_tuser (arm a wait, one received
// serial byte, or a one millisecond tick) and its arguments in in_tdata. After an arm,
// received bytes are parsed as a frame; each payload byte comes out as a result with
// out_tuser low, and the end of the wait (ok, checksum mismatch or timeout) comes out
// as a result with out_tuser high. Most requests produce no result at all.
// A request accepted into the input register is parsed when it advances from there, and
// its result, if any, is loaded into the output register by that parse step. Throughput
// is one request per cycle while the output register is free or out_tready is high, set
// by the single parse step between the input register and the result register.
// When out_tready is low, a pending result holds, the parser stalls and the input
// register fills, after which in_tready drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, puts the parser in idle and
// restores the configuration registers to their default values. Configuration writes
// on cfg_we take effect at once and are expected only while the block is idle.
module response_frame_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [0] wait_data, [16:1] timeout_ticks, [24:17] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] byte_index, [23:16] payload_byte, [25:24] outcome, [33:26] confirm_code,
  // [41:34] frame_type
  output logic [47:0] out_tdata,
  output logic        out_tuser,  // [0] kind
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import rfr_pkg::*;

  cfg_t    cfg_r;
  item_t   item_r;
  logic    item_v_r;
  result_t res_r;
  logic    res_v_r;

  logic    advance;
  logic    in_take;
  logic    pr_valid;
  result_t pr_res;

  assign advance   = item_v_r && (!res_v_r || out_tready);
  assign in_tready = !item_v_r || advance;
  assign in_take   = in_tvalid && in_tready;

  rfr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (advance),
    .item_i      (item_r),
    .cfg_i       (cfg_r),
    .res_valid_o (pr_valid),
    .res_o       (pr_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tready) begin
      item_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.cmd           <= in_tuser;
      item_r.wait_data     <= in_tdata[0];
      item_r.timeout_ticks <= in_tdata[16:1];
      item_r.rx_byte       <= in_tdata[24:17];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (advance) begin
      res_v_r <= pr_valid;
    end else if (out_tready) begin
      res_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pr_valid) begin
      res_r <= pr_res;
    end
  end

  assign out_tvalid = res_v_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {6'd0, res_r.frame_type, res_r.confirm_code, res_r.outcome,
                       res_r.payload_byte, res_r.byte_index};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_word <= RST_HEADER_WORD;
      cfg_r.ack_type    <= RST_ACK_TYPE;
      cfg_r.data_type   <= RST_DATA_TYPE;
      cfg_r.last_type   <= RST_LAST_TYPE;
      cfg_r.max_payload <= RST_MAX_PAYLOAD;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HEADER_WORD: cfg_r.header_word <= cfg_wdata;
        REG_ACK_TYPE:    cfg_r.ack_type    <= cfg_wdata[7:0];
        REG_DATA_TYPE:   cfg_r.data_type   <= cfg_wdata[7:0];
        REG_LAST_TYPE:   cfg_r.last_type   <= cfg_wdata[7:0];
        REG_MAX_PAYLOAD: cfg_r.max_payload <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule
